@@ sv/fpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsa_pkg: shared types and constants of the free page stack allocator
// Page geometry, request and status codes, command and result records.
// ----------------------------------------------------------------------------
package fpsa_pkg;

    // page store geometry
    localparam int MAX_PAGES  = 16384;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int ADDED_W    = 15;
    localparam int STATUS_W   = 2;

    // port widths
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 2 * ADDR_W;
    localparam int RES_W       = ADDR_W + STATUS_W + ADDED_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // request codes on the input channel
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_RANGE = 2'd2
    } req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_END = 2'd0,
        CFG_PHYS_TOP   = 2'd1,
        CFG_KERN_BASE  = 2'd2
    } cfg_idx_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_RANGE,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ADDR_W-1:0]  addr;    // page to free, or rounded range start
        logic [ADDR_W-1:0]  limit;   // exclusive range end
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] kernel_end;
        logic [ADDR_W-1:0] phys_top;
        logic [ADDR_W-1:0] kern_base;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  page_addr;
        status_t            status;
        logic [ADDED_W-1:0] pages_added;
    } result_t;

    // back-end status seen by the top level checks
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } back_stat_t;

endpackage

@@ sv/free_page_stack_allocator_top.sv @@
// ----------------------------------------------------------------------------
// free_page_stack_allocator_top: free page stack allocator
// LIFO page allocator with checked single and range frees.
//
//  channel  direction  ports                 contents (low bit up)
//  s_       in         tvalid tready tdata   addr[31:0] range_end[63:32]
//                      tuser                 req_type[1:0]
//  m_       out        tvalid tready tdata   page_addr[31:0] status[33:32]
//                                            pages_added[48:34]
//  cfg_     in         wr_en index wdata     0 kernel_end 1 phys_top 2 kern_base
//
// Single free, unknown and empty-stack allocate requests finish in the idle
// state of the back end; an allocate also passes through the pop state (one
// stack memory read port, registered); a range free walks its pages one at a
// time in the walk state, then ends with an end or fault step. A two-entry command queue lets
// requests enter while the back end is busy or a result waits on m_tready. Reset is synchronous; the stack memory
// is not cleared, since entries above the count are never read. No clearing pass.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_top import fpsa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // addr, range_end
    input  logic [REQ_W-1:0]        s_tuser,   // req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // page_addr, status, pages_added
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_wdata
);

    cfg_t        cfg_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    result_t     res;
    back_stat_t  stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kernel_end <= '0;
            cfg_reg.phys_top   <= ADDR_W'(32'h0E00_0000);
            cfg_reg.kern_base  <= ADDR_W'(32'h8000_0000);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KERNEL_END: cfg_reg.kernel_end <= cfg_wdata;
                CFG_PHYS_TOP:   cfg_reg.phys_top   <= cfg_wdata;
                CFG_KERN_BASE:  cfg_reg.kern_base  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fpsa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_addr   (s_tdata[ADDR_W-1:0]),
        .in_end    (s_tdata[2*ADDR_W-1:ADDR_W]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fpsa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .stat      (stat)
    );

    // pack the result, zero fill to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}},
                      res.pages_added, res.status, res.page_addr};

    // no result is held while the back end is mid-operation
    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !m_tvalid)
        else $error("result pending while back end busy");

    // the page count never exceeds the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CNT_W'(MAX_PAGES))
        else $error("page count beyond store depth");

    // an empty status carries no page and no pushes
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.status == STAT_EMPTY) |->
            (res.page_addr == '0 && res.pages_added == '0))
        else $error("empty result carries data");

    // a pop lowers the count by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready && cmd.kind == CMD_ALLOC && stat.count != '0)
            |=> (stat.count == $past(stat.count) - CNT_W'(1)))
        else $error("allocate did not decrement count");

endmodule

@@ sv/fpsa_front.sv @@
// ----------------------------------------------------------------------------
// fpsa_front: request intake
// Decodes each request, rounds range starts up to a page, and queues the
// resulting command in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module fpsa_front import fpsa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      in_req,
    input  logic [ADDR_W-1:0]     in_addr,
    input  logic [ADDR_W-1:0]     in_end,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output cmd_t                  cmd
);

    cmd_t              q_mem [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        fill_reg;
    cmd_t              new_cmd;
    logic [ADDR_W-1:0] rounded;
    logic              push, pop;

    // round up to a page boundary, wrapping at 2^32
    assign rounded = (in_addr + ADDR_W'(PAGE_BYTES - 1)) &
                     ~ADDR_W'(PAGE_BYTES - 1);

    // classify the request
    always_comb begin
        new_cmd.addr  = in_addr;
        new_cmd.limit = in_end;
        unique case (in_req)
            REQ_ALLOC: new_cmd.kind = CMD_ALLOC;
            REQ_FREE:  new_cmd.kind = CMD_FREE;
            REQ_RANGE: begin
                new_cmd.kind = CMD_RANGE;
                new_cmd.addr = rounded;
            end
            default:   new_cmd.kind = CMD_NOP;
        endcase
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ sv/fpsa_back.sv @@
// ----------------------------------------------------------------------------
// fpsa_back: command execution
// Holds the page stack memory and its count, walks ranges one page a cycle,
// and keeps the output register.
// ----------------------------------------------------------------------------
module fpsa_back import fpsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res,
    output back_stat_t  stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_WALK = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next, count_dec;
    logic [ADDR_W-1:0]   walk_addr_reg, walk_addr_next;
    logic [ADDR_W-1:0]   walk_limit_reg, walk_limit_next;
    logic [ADDED_W-1:0]  added_reg, added_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;

    logic [PN_W-1:0]     stack_mem [MAX_PAGES];
    logic [PN_W-1:0]     rd_data_reg;
    logic                mem_we, rd_en;

    logic [ADDR_W-1:0]   chk_addr, phys;
    logic                chk_ok, full, out_free, walk_done;

    // page check on the single address or the walk cursor
    assign chk_addr = (state_reg == ST_WALK) ? walk_addr_reg : cmd.addr;
    assign phys     = chk_addr - cfg.kern_base;
    assign chk_ok   = (chk_addr[PAGE_SHIFT-1:0] == '0) &&
                      (chk_addr >= cfg.kernel_end) && (phys < cfg.phys_top);
    assign full     = (count_reg == CNT_W'(MAX_PAGES));
    assign count_dec = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || out_ready;
    // end of range test without wrap
    assign walk_done = ({1'b0, walk_addr_reg} + (ADDR_W + 1)'(PAGE_BYTES)) >
                       {1'b0, walk_limit_reg};

    // stack memory, write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[count_reg[IDX_W-1:0]] <= chk_addr[ADDR_W-1:PAGE_SHIFT];
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[count_dec[IDX_W-1:0]];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_addr_next  = walk_addr_reg;
        walk_limit_next = walk_limit_reg;
        added_next      = added_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_res_next    = out_res_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        cmd_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready                = 1'b1;
                    out_res_next.page_addr   = '0;
                    out_res_next.status      = STAT_OK;
                    out_res_next.pages_added = '0;
                    case (cmd.kind)
                        CMD_ALLOC: begin
                            if (count_reg == '0) begin
                                out_valid_next      = 1'b1;
                                out_res_next.status = STAT_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                count_next = count_dec;
                                state_next = ST_POP;
                            end
                        end
                        CMD_FREE: begin
                            out_valid_next = 1'b1;
                            if (!chk_ok) begin
                                out_res_next.status = STAT_BAD;
                            end else if (full) begin
                                out_res_next.status = STAT_FULL;
                            end else begin
                                mem_we                   = 1'b1;
                                count_next               = count_reg + CNT_W'(1);
                                out_res_next.pages_added = ADDED_W'(1);
                            end
                        end
                        CMD_RANGE: begin
                            walk_addr_next  = cmd.addr;
                            walk_limit_next = cmd.limit;
                            added_next      = '0;
                            state_next      = ST_WALK;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                out_valid_next           = 1'b1;
                out_res_next.page_addr   = {rd_data_reg, {PAGE_SHIFT{1'b0}}};
                out_res_next.status      = STAT_OK;
                out_res_next.pages_added = '0;
                state_next               = ST_IDLE;
            end
            ST_WALK: begin
                out_res_next.page_addr   = '0;
                out_res_next.pages_added = added_reg;
                if (walk_done) begin
                    out_valid_next      = 1'b1;
                    out_res_next.status = STAT_OK;
                    state_next          = ST_IDLE;
                end else if (!chk_ok) begin
                    out_valid_next      = 1'b1;
                    out_res_next.status = STAT_BAD;
                    state_next          = ST_IDLE;
                end else if (full) begin
                    out_valid_next      = 1'b1;
                    out_res_next.status = STAT_FULL;
                    state_next          = ST_IDLE;
                end else begin
                    mem_we         = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    added_next     = added_reg + ADDED_W'(1);
                    walk_addr_next = walk_addr_reg + ADDR_W'(PAGE_BYTES);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            walk_addr_reg  <= '0;
            walk_limit_reg <= '0;
            added_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            walk_addr_reg  <= walk_addr_next;
            walk_limit_reg <= walk_limit_next;
            added_reg      <= added_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;
    assign stat.busy  = (state_reg != ST_IDLE);
    assign stat.count = count_reg;

endmodule

@@ sim/fpsa_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpsa_checker: result checker for the free page stack allocator
// Watches the request, result and register write ports, keeps its own copy
// of the page stack and registers, works out the result of every accepted
// request and compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module fpsa_checker import fpsa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // addr, range_end
    input  logic [REQ_W-1:0]        s_tuser,   // req_type
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,   // page_addr, status, pages_added
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADDR_W-1:0]       cfg_wdata,
    output int                      errors,
    output int                      pending
);

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 32'h0E00_0000;
    localparam logic [ADDR_W-1:0] KERN_BASE_RST  = 32'h8000_0000;

    typedef struct {
        logic [ADDR_W-1:0]   page_addr;
        logic [STATUS_W-1:0] status;
        logic [ADDED_W-1:0]  added;
    } grant_t;

    // shadow of the page stack and the registers
    logic [PN_W-1:0]   free_pages [MAX_PAGES];
    int unsigned       free_depth;
    logic [ADDR_W-1:0] kernel_end_q;
    logic [ADDR_W-1:0] phys_top_q;
    logic [ADDR_W-1:0] kern_base_q;

    // results owed by the block, oldest first
    grant_t grants_due[$];

    // validate one page and push it on the stack
    function automatic status_t check_and_push(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] phys;
        phys = a - kern_base_q;
        if (a[PAGE_SHIFT-1:0] != '0 || a < kernel_end_q || phys >= phys_top_q)
            return STAT_BAD;
        if (free_depth >= MAX_PAGES)
            return STAT_FULL;
        free_pages[free_depth] = a[ADDR_W-1:PAGE_SHIFT];
        free_depth++;
        return STAT_OK;
    endfunction

    // apply one request to the shadow state and return its result
    function automatic grant_t serve(input logic [REQ_W-1:0]  req,
                                     input logic [ADDR_W-1:0] a,
                                     input logic [ADDR_W-1:0] lim);
        grant_t        g;
        logic [ADDR_W:0] cursor;
        logic          walking;
        g.page_addr = '0;
        g.status    = STAT_OK;
        g.added     = '0;
        case (req)
            REQ_ALLOC: begin
                if (free_depth == 0) begin
                    g.status = STAT_EMPTY;
                end else begin
                    free_depth--;
                    g.page_addr = {free_pages[free_depth], {PAGE_SHIFT{1'b0}}};
                end
            end
            REQ_FREE: begin
                g.status = check_and_push(a);
                if (g.status == STAT_OK)
                    g.added = ADDED_W'(1);
            end
            REQ_RANGE: begin
                // round start up; a start in the top partial page wraps to 0
                cursor = {1'b0, a} + (PAGE_BYTES - 1);
                cursor[PAGE_SHIFT-1:0] = '0;
                cursor[ADDR_W] = 1'b0;
                walking = 1'b1;
                // end test is done on 33 bits, so it never wraps
                while (walking) begin
                    if (cursor + PAGE_BYTES > {1'b0, lim}) begin
                        walking = 1'b0;
                    end else begin
                        g.status = check_and_push(cursor[ADDR_W-1:0]);
                        if (g.status != STAT_OK) begin
                            walking = 1'b0;
                        end else begin
                            g.added = g.added + 1'b1;
                            cursor  = cursor + PAGE_BYTES;
                        end
                    end
                end
            end
            default: ;  // unknown request: no change
        endcase
        return g;
    endfunction

    // sample all ports at the rising edge
    always @(posedge aclk) begin : watch
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            free_depth   = 0;
            kernel_end_q = KERNEL_END_RST;
            phys_top_q   = PHYS_TOP_RST;
            kern_base_q  = KERN_BASE_RST;
            grants_due.delete();
            errors = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KERNEL_END: kernel_end_q = cfg_wdata;
                    CFG_PHYS_TOP:   phys_top_q   = cfg_wdata;
                    CFG_KERN_BASE:  kern_base_q  = cfg_wdata;
                    default: ;
                endcase
            end
            // results are matched before this edge's request is applied
            if (m_tvalid && m_tready) begin
                got.page_addr = m_tdata[ADDR_W-1:0];
                got.status    = m_tdata[ADDR_W +: STATUS_W];
                got.added     = m_tdata[ADDR_W+STATUS_W +: ADDED_W];
                if (grants_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got %h %0d %0d",
                             $time, got.page_addr, got.status, got.added);
                end else begin
                    want = grants_due.pop_front();
                    if (got.page_addr !== want.page_addr) begin
                        errors++;
                        $display("%0t: page_addr expected %h got %h",
                                 $time, want.page_addr, got.page_addr);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.added !== want.added) begin
                        errors++;
                        $display("%0t: pages_added expected %0d got %0d",
                                 $time, want.added, got.added);
                    end
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(serve(s_tuser, s_tdata[ADDR_W-1:0],
                                           s_tdata[ADDR_W +: ADDR_W]));
        end
        pending = grants_due.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: free page stack allocator
// Drives allocate, single free, range free and unknown requests under several
// register settings, with random gaps and back-pressure, including one long
// receiver stall and a run that fills the page stack. The checker instance
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import fpsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [ADDR_W-1:0]      cfg_wdata;
    int                     mismatches;
    int                     in_flight;

    // register values in force, used only to aim addresses
    logic [ADDR_W-1:0] win_kernel_end;
    logic [ADDR_W-1:0] win_phys_top;
    logic [ADDR_W-1:0] win_kern_base;

    bit gaps_on = 1'b1;
    bit quiet   = 1'b0;
    bit hold_go = 1'b0;

    free_page_stack_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fpsa_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (mismatches),
        .pending   (in_flight)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // offer one request, optionally after a gap; returns once accepted
    task automatic send(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] a,
                        input logic [ADDR_W-1:0] lim);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {lim, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid and wait until every result has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [ADDR_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_regs(input logic [ADDR_W-1:0] ke, input logic [ADDR_W-1:0] pt,
                            input logic [ADDR_W-1:0] kb);
        settle();
        cfg_write(CFG_KERNEL_END, ke);
        cfg_write(CFG_PHYS_TOP, pt);
        cfg_write(CFG_KERN_BASE, kb);
        win_kernel_end = ke;
        win_phys_top   = pt;
        win_kern_base  = kb;
    endtask

    // page address aimed at the valid window and its edges
    function automatic logic [ADDR_W-1:0] good_addr();
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] pg;
        span = win_phys_top >> PAGE_SHIFT;
        case ($urandom_range(0, 3))
            0: pg = span - $urandom_range(0, 2);
            1: return {win_kernel_end[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                      + ($urandom_range(0, 2) << PAGE_SHIFT) - PAGE_BYTES;
            default: pg = $urandom_range(0, (span > 0 && span < 512) ? span - 1 : 511);
        endcase
        return win_kern_base + (pg << PAGE_SHIFT);
    endfunction

    // mostly well-formed requests, some misaligned and some pure noise
    task automatic random_item();
        int unsigned       pick;
        int unsigned       n;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] e;
        logic [REQ_W-1:0]  req;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send(REQ_ALLOC, $urandom, $urandom);
        end else if (pick < 72) begin
            send(REQ_FREE, good_addr(), $urandom);
        end else if (pick < 87) begin
            a = good_addr();
            if ($urandom_range(0, 1))
                a = a - $urandom_range(0, PAGE_BYTES - 1);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
            e = a + n * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
            send(REQ_RANGE, a, e);
        end else if (pick < 92) begin
            send(REQ_FREE, good_addr() | $urandom_range(1, PAGE_BYTES - 1), $urandom);
        end else begin
            req = REQ_W'($urandom_range(0, 3));
            a   = $urandom;
            // keep noise ranges short so they cannot flood the stack
            e   = (req == REQ_RANGE) ? a + $urandom_range(0, 16 * PAGE_BYTES) : $urandom;
            send(req, a, e);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] ke, input logic [ADDR_W-1:0] pt,
                             input logic [ADDR_W-1:0] kb, input int count,
                             input bit with_hold);
        set_regs(ke, pt, kb);
        if (with_hold) begin
            @(posedge aclk);
            hold_go = 1'b1;
        end
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            random_item();
        end
    endtask

    // receiver: ready runs, stall bursts, and one long hold on request
    initial begin : receiver
        int hold_left;
        int stall_left;
        int ready_left;
        hold_left  = 0;
        stall_left = 0;
        ready_left = 0;
        m_tready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_tready = 1'b1;
            end else if (ready_left > 0) begin
                m_tready = 1'b1;
                ready_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                          : $urandom_range(1, 25);
                stall_left = $urandom_range(1, 18);
            end
        end
    end

    // watchdog on cycles without any item moving
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        @(posedge aresetn);
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("testbench: errors");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_ALLOC;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_KERNEL_END;
        cfg_wdata = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed: low window with page zero usable
        set_regs(32'h0000_0000, 32'h0010_0000, 32'h0000_0000);
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);   // empty stack
        send(REQ_FREE,  32'h0000_0000, 32'h0000_0000);   // page zero
        send(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // returns page zero
        send(REQ_FREE,  32'h0000_1001, 32'h0000_0000);   // misaligned
        send(REQ_FREE,  32'h0010_0000, 32'h0000_0000);   // at physical top
        send(REQ_FREE,  32'h000F_F000, 32'h0000_0000);   // last page below top
        send(REQ_RANGE, 32'hFFFF_F001, 32'h0000_3000);   // start wraps to zero
        send(REQ_RANGE, 32'h0000_5000, 32'h0000_5FFF);   // empty range
        send(REQ_RANGE, 32'hFFFF_F000, 32'hFFFF_FFFF);   // end test must not wrap
        send(REQ_RANGE, 32'h000F_D000, 32'h0010_2000);   // faults after three pages
        send(REQ_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unknown request
        send(REQ_FREE,  32'hFFFF_F000, 32'h0000_0000);   // far above top
        repeat (3) send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);

        // directed: kernel end boundary
        set_regs(32'h0008_0000, 32'h0010_0000, 32'h0000_0000);
        send(REQ_FREE,  32'h0007_F000, 32'h0000_0000);   // just below kernel end
        send(REQ_FREE,  32'h0008_0000, 32'h0000_0000);   // at kernel end
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);

        // random phases over several register settings
        run_phase(32'h8000_0000, 32'h0E00_0000, 32'h8000_0000, 500, 1'b1);
        run_phase(32'h8004_0000, 32'h0010_0000, 32'h8000_0000, 300, 1'b0);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 500, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 100, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_0000, 32'h1234_5000, 100, 1'b0);
        run_phase(32'h0000_1000, 32'h0001_0000, 32'hFFFF_F000, 300, 1'b0);

        // closing pass without idling: fill the stack to its limit
        @(posedge aclk);
        quiet   = 1'b1;
        gaps_on = 1'b0;
        set_regs(32'h0000_0000, 32'h0E00_0000, 32'h8000_0000);
        send(REQ_RANGE, 32'h8000_0000, 32'h8000_0000 + (MAX_PAGES + 1) * PAGE_BYTES);
        send(REQ_FREE,  32'h8000_0000, 32'h0000_0000);   // stack full
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
        send(REQ_FREE,  32'h8E00_0000, 32'h0000_0000);   // at physical top
        send(REQ_FREE,  32'h8000_1000, 32'h0000_0000);
        send(REQ_RANGE, 32'h8000_2000, 32'h8000_4000);   // one page, then full
        send(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fpsa_pkg.sv
sv/fpsa_front.sv
sv/fpsa_back.sv
sv/free_page_stack_allocator_top.sv
sim/fpsa_checker.sv
sim/testbench.sv
